### rtl/qwdd_pkg.sv
// Shared constants and types for the quadrature wheel detent decoder.
package qwdd_pkg;

  localparam int DEBOUNCE_DEPTH = 2;
  localparam int SLOT_W = (DEBOUNCE_DEPTH > 1) ? $clog2(DEBOUNCE_DEPTH) : 1;

  localparam int PPD_W = 4;
  localparam int REL_W = 8;
  localparam int POS_W = 6;
  localparam int IDLE_W = 8;

  localparam logic [PPD_W-1:0] PPD_RESET = 4'd2;
  localparam logic [REL_W-1:0] REL_RESET = 8'd20;
  localparam logic [IDLE_W-1:0] IDLE_MAX = 8'hFF;

  // Register indexes (byte address bit 2).
  localparam logic REG_PPD = 1'b0;
  localparam logic REG_REL = 1'b1;

  // Transition codes: {debounced pair, accepted pair}.
  localparam logic [3:0] CODE_CW0 = 4'h1;
  localparam logic [3:0] CODE_CW1 = 4'h8;
  localparam logic [3:0] CODE_CW2 = 4'h7;
  localparam logic [3:0] CODE_CW3 = 4'hE;
  localparam logic [3:0] CODE_CCW0 = 4'hB;
  localparam logic [3:0] CODE_CCW1 = 4'h4;
  localparam logic [3:0] CODE_CCW2 = 4'h2;
  localparam logic [3:0] CODE_CCW3 = 4'hD;
  localparam logic [3:0] CODE_SAME0 = 4'h0;
  localparam logic [3:0] CODE_SAME1 = 4'h5;
  localparam logic [3:0] CODE_SAME2 = 4'hA;
  localparam logic [3:0] CODE_SAME3 = 4'hF;

  localparam logic signed [1:0] STEP_CW = 2'sb01;
  localparam logic signed [1:0] STEP_CCW = 2'sb11;
  localparam logic signed [1:0] STEP_NONE = 2'sb00;

  typedef struct packed {
    logic [PPD_W-1:0] detent_limit;
    logic [REL_W-1:0] release_ticks;
  } cfg_t;

  typedef struct packed {
    logic signed [1:0] detent_step;
    logic              bad_transition;
    logic              scanning;
    logic [1:0]        debounced_lines;
  } result_t;

endpackage

### rtl/qwdd_sample_if.sv
// Handshake channel carrying one pair of raw encoder line samples.
interface qwdd_sample_if;
  logic valid;
  logic ready;
  logic line_zero;
  logic line_one;

  modport source (output valid, output line_zero, output line_one, input ready);
  modport sink (input valid, input line_zero, input line_one, output ready);
endinterface

### rtl/qwdd_result_if.sv
// Handshake channel carrying one decoder result item.
interface qwdd_result_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] detent_step;
  logic              bad_transition;
  logic              scanning;
  logic [1:0]        debounced_lines;

  modport source (output valid, output detent_step, output bad_transition,
                  output scanning, output debounced_lines, input ready);
  modport sink (input valid, input detent_step, input bad_transition,
                input scanning, input debounced_lines, output ready);
endinterface

### rtl/quadrature_wheel_detent_decoder_unit.sv
// Top level: APB registers, input register, decoder core and result register.
// Debounces raw two-line quadrature samples and decodes them into wheel detent
// steps. Each accepted sample pair yields exactly one result item: the detent
// step (+1, -1 or 0), a flag for an impossible line transition, the scanning
// flag and the debounced pair. An item passes through an input register into
// the result register, which offers its result on the result channel. The
// rate is one item per cycle for as long as the result side keeps taking
// items; a stalled result side holds the input once both registers are full.
// Registers: the detent threshold at byte address 0 and release_ticks at
// byte address 4; write them only while no item is in flight.
module quadrature_wheel_detent_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  qwdd_sample_if.sink in_ch,
  qwdd_result_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import qwdd_pkg::*;

  cfg_t       cfg;
  logic       cfg_write;

  logic       in_valid;
  logic [1:0] in_sample;
  logic       out_valid;
  result_t    out_result;
  result_t    core_result;
  logic       advance;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detent_limit  <= PPD_RESET;
      cfg.release_ticks <= REL_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_PPD: cfg.detent_limit  <= pwdata[PPD_W-1:0];
        REG_REL: cfg.release_ticks <= pwdata[REL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PPD: prdata = {{(32 - PPD_W){1'b0}}, cfg.detent_limit};
      REG_REL: prdata = {{(32 - REL_W){1'b0}}, cfg.release_ticks};
      default: prdata = '0;
    endcase
  end

  // Move the held item into the result register when that slot frees up.
  assign advance     = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_sample <= {in_ch.line_one, in_ch.line_zero};
    end
  end

  qwdd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .sample  (in_sample),
    .cfg     (cfg),
    .result  (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.detent_step     = out_result.detent_step;
  assign out_ch.bad_transition  = out_result.bad_transition;
  assign out_ch.scanning        = out_result.scanning;
  assign out_ch.debounced_lines = out_result.debounced_lines;

endmodule

### rtl/qwdd_core.sv
// Debounce ring, transition decode, detent accumulator and idle counter.
module qwdd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [1:0]       sample,
  input  qwdd_pkg::cfg_t   cfg,
  output qwdd_pkg::result_t result
);
  import qwdd_pkg::*;

  logic [1:0]              sample_ring [DEBOUNCE_DEPTH];
  logic [SLOT_W-1:0]       ring_slot;
  logic [1:0]              accepted_lines;
  logic signed [POS_W-1:0] pulse_position;
  logic [IDLE_W-1:0]       idle_count;

  logic [SLOT_W-1:0]       ring_slot_next;
  logic [1:0]              pair;
  logic [3:0]              code;
  logic                    move_cw;
  logic                    move_ccw;
  logic                    bad;
  logic signed [POS_W-1:0] pos_moved;
  logic signed [POS_W-1:0] pulse_position_next;
  logic signed [POS_W-1:0] limit;
  logic [1:0]              accepted_lines_next;
  logic [IDLE_W-1:0]       idle_base;
  logic [IDLE_W-1:0]       idle_count_next;
  logic signed [1:0]       step;

  always_comb begin
    if (ring_slot == SLOT_W'(DEBOUNCE_DEPTH - 1)) begin
      ring_slot_next = '0;
    end else begin
      ring_slot_next = ring_slot + SLOT_W'(1);
    end
  end

  // A line is high only if high in every stored sample, the new one included.
  always_comb begin
    pair = 2'b11;
    for (int i = 0; i < DEBOUNCE_DEPTH; i++) begin
      if (ring_slot_next == SLOT_W'(i)) begin
        pair = pair & sample;
      end else begin
        pair = pair & sample_ring[i];
      end
    end
  end

  assign code = {pair, accepted_lines};

  always_comb begin
    move_cw  = 1'b0;
    move_ccw = 1'b0;
    bad      = 1'b0;
    case (code) inside
      CODE_CW0, CODE_CW1, CODE_CW2, CODE_CW3:         move_cw = 1'b1;
      CODE_CCW0, CODE_CCW1, CODE_CCW2, CODE_CCW3:     move_ccw = 1'b1;
      CODE_SAME0, CODE_SAME1, CODE_SAME2, CODE_SAME3: ;
      default:                                        bad = 1'b1;
    endcase
  end

  assign limit = $signed({{(POS_W - PPD_W){1'b0}}, cfg.detent_limit});

  always_comb begin
    if (move_cw) begin
      pos_moved = pulse_position + POS_W'(1);
    end else if (move_ccw) begin
      pos_moved = pulse_position - POS_W'(1);
    end else begin
      pos_moved = pulse_position;
    end
    step = STEP_NONE;
    pulse_position_next = pos_moved;
    if (pos_moved > limit) begin
      step = STEP_CW;
      pulse_position_next = '0;
    end else if (pos_moved < -limit) begin
      step = STEP_CCW;
      pulse_position_next = '0;
    end
  end

  assign accepted_lines_next = (move_cw || move_ccw) ? pair : accepted_lines;
  assign idle_base = (move_cw || move_ccw) ? '0 : idle_count;
  assign idle_count_next = (idle_base == IDLE_MAX) ? idle_base : idle_base + IDLE_W'(1);

  assign result.detent_step     = step;
  assign result.bad_transition  = bad;
  assign result.scanning        = (idle_base < cfg.release_ticks);
  assign result.debounced_lines = pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEBOUNCE_DEPTH; i++) begin
        sample_ring[i] <= '0;
      end
      ring_slot      <= '0;
      accepted_lines <= '0;
      pulse_position <= '0;
      idle_count     <= '0;
    end else if (advance) begin
      sample_ring[ring_slot_next] <= sample;
      ring_slot      <= ring_slot_next;
      accepted_lines <= accepted_lines_next;
      pulse_position <= pulse_position_next;
      idle_count     <= idle_count_next;
    end
  end

endmodule

### sim/tb_quadrature_wheel_detent_decoder_unit.sv
// Self-checking testbench for the quadrature wheel detent decoder unit.
module tb_quadrature_wheel_detent_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import qwdd_pkg::*;

  localparam int NUM_PHASES = 7;
  localparam int PHASE_SPAN [NUM_PHASES] = '{0, 15, 1, 2, 7, 15, 0};
  localparam int PHASE_RELEASE [NUM_PHASES] = '{0, 255, 1, 20, 128, 0, 255};
  localparam int PHASE_SEND_GAP [NUM_PHASES] = '{10, 0, 0, 10, 10, 0, 10};
  localparam int PHASE_RECV_GAP [NUM_PHASES] = '{10, 0, 10, 0, 10, 10, 0};
  localparam int PHASE_ITEMS = 55;
  localparam int STILL_ITEMS = 270;
  localparam int LONG_HOLD = 60;
  localparam int WATCHDOG_LIMIT = 3000;

  // Gray order of the two lines, bit0 first line: clockwise 00-10-11-01.
  localparam logic [1:0] CW_NEXT [4] = '{2'b10, 2'b00, 2'b11, 2'b01};
  localparam logic [1:0] CCW_NEXT [4] = '{2'b01, 2'b11, 2'b00, 2'b10};

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  qwdd_sample_if sample_ch ();
  qwdd_result_if result_ch ();

  quadrature_wheel_detent_decoder_unit dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (sample_ch),
    .out_ch  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Decoder state as the block should hold it.
  logic [1:0]        tap_ring [DEBOUNCE_DEPTH];
  int                tap_slot;
  logic [1:0]        held_lines;
  int                wheel_pos;
  logic [IDLE_W-1:0] idle_ticks;
  logic [PPD_W-1:0]  detent_span;
  logic [REL_W-1:0]  release_span;

  logic [1:0] pending_pairs [$];
  result_t    wheel_reports [$];

  int   mismatches;
  int   queued_total;
  int   send_gap_max;
  int   recv_gap_max;
  int   send_wait;
  int   recv_wait;
  int   long_left;
  int   hold_requests;
  int   holds_served;
  int   quiet_cycles;
  logic spin_cw;
  logic [1:0] wheel_raw;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic void wheel_reset();
    for (int i = 0; i < DEBOUNCE_DEPTH; i++)
      tap_ring[i] = 2'b00;
    tap_slot = 0;
    held_lines = 2'b00;
    wheel_pos = 0;
    idle_ticks = '0;
    detent_span = PPD_RESET;
    release_span = REL_RESET;
  endfunction

  function automatic result_t decode_tick(input logic [1:0] raw);
    result_t    rpt;
    logic [1:0] deb;
    logic [3:0] code;
    int         span;
    // advance the slot first, then store the sample there
    tap_slot = (tap_slot + 1) % DEBOUNCE_DEPTH;
    tap_ring[tap_slot] = raw;
    deb = 2'b11;
    for (int i = 0; i < DEBOUNCE_DEPTH; i++)
      deb = deb & tap_ring[i];
    code = {deb, held_lines};
    rpt = '0;
    case (code)
      CODE_CW0, CODE_CW1, CODE_CW2, CODE_CW3: begin
        wheel_pos = wheel_pos + 1;
        idle_ticks = '0;
        held_lines = deb;
      end
      CODE_CCW0, CODE_CCW1, CODE_CCW2, CODE_CCW3: begin
        wheel_pos = wheel_pos - 1;
        idle_ticks = '0;
        held_lines = deb;
      end
      CODE_SAME0, CODE_SAME1, CODE_SAME2, CODE_SAME3: begin
      end
      default: rpt.bad_transition = 1'b1;
    endcase
    span = detent_span;
    if (wheel_pos > span) begin
      rpt.detent_step = STEP_CW;
      wheel_pos = 0;
    end
    if (wheel_pos < -span) begin
      rpt.detent_step = STEP_CCW;
      wheel_pos = 0;
    end
    if (rpt.detent_step != STEP_CW && rpt.detent_step != STEP_CCW)
      rpt.detent_step = STEP_NONE;
    rpt.scanning = (idle_ticks < release_span);
    if (idle_ticks != IDLE_MAX)
      idle_ticks = idle_ticks + 1'b1;
    rpt.debounced_lines = deb;
    return rpt;
  endfunction

  task automatic write_reg(input logic idx, input logic [31:0] val);
    logic [31:0] keep;
    keep = (idx == REG_PPD) ? 32'h0000_000F : 32'h0000_00FF;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    // junk above the register width must be dropped
    pwdata <= (val & keep) | ($urandom & ~keep);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_PPD)
      detent_span = val[PPD_W-1:0];
    else
      release_span = val[REL_W-1:0];
    @(negedge clk);
  endtask

  task automatic check_reg(input logic idx, input logic [31:0] want);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    if (prdata !== want)
      flag_mismatch($sformatf("register %0d read %h, want %h", idx, prdata, want));
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_pair(input logic [1:0] pair, input int ticks);
    for (int i = 0; i < ticks; i++) begin
      pending_pairs.push_back(pair);
      queued_total++;
    end
  endtask

  // Mostly clean rotation with random dwell, plus glitches and skipped states.
  task automatic queue_turns(input int count);
    int start;
    int pick;
    start = queued_total;
    while (queued_total - start < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        if ($urandom_range(0, 7) == 0)
          spin_cw = ~spin_cw;
        wheel_raw = spin_cw ? CW_NEXT[wheel_raw] : CCW_NEXT[wheel_raw];
        push_pair(wheel_raw, ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 4));
      end else if (pick == 7) begin
        push_pair(2'($urandom_range(0, 3)), 1);
      end else if (pick == 8) begin
        wheel_raw = ~wheel_raw;
        push_pair(wheel_raw, $urandom_range(2, 3));
      end else begin
        push_pair(wheel_raw, $urandom_range(1, 6));
      end
    end
  endtask

  task automatic drain_results();
    while (pending_pairs.size() != 0 || sample_ch.valid || wheel_reports.size() != 0)
      @(negedge clk);
    // let the input and result registers settle
    repeat (4) @(negedge clk);
  endtask

  // Sample driver.
  always @(posedge clk) begin
    logic [1:0] nxt;
    if (rst) begin
      sample_ch.valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready)
        wheel_reports.push_back(decode_tick({sample_ch.line_one, sample_ch.line_zero}));
      if (!sample_ch.valid || sample_ch.ready) begin
        if (send_wait > 0) begin
          send_wait <= send_wait - 1;
          sample_ch.valid <= 1'b0;
        end else if (pending_pairs.size() != 0) begin
          nxt = pending_pairs.pop_front();
          sample_ch.line_zero <= nxt[0];
          sample_ch.line_one <= nxt[1];
          sample_ch.valid <= 1'b1;
          send_wait <= $urandom_range(0, send_gap_max);
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk) begin
    int      wait_now;
    result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      recv_wait <= 0;
      long_left <= 0;
      holds_served <= 0;
    end else begin
      wait_now = recv_wait;
      if (result_ch.valid && result_ch.ready) begin
        if (wheel_reports.size() == 0) begin
          flag_mismatch("result item with nothing outstanding");
        end else begin
          want = wheel_reports.pop_front();
          if (result_ch.detent_step !== want.detent_step)
            flag_mismatch($sformatf("detent_step %0d, want %0d",
                                    result_ch.detent_step, want.detent_step));
          if (result_ch.bad_transition !== want.bad_transition)
            flag_mismatch($sformatf("bad_transition %b, want %b",
                                    result_ch.bad_transition, want.bad_transition));
          if (result_ch.scanning !== want.scanning)
            flag_mismatch($sformatf("scanning %b, want %b",
                                    result_ch.scanning, want.scanning));
          if (result_ch.debounced_lines !== want.debounced_lines)
            flag_mismatch($sformatf("debounced_lines %b, want %b",
                                    result_ch.debounced_lines, want.debounced_lines));
        end
        wait_now = $urandom_range(0, recv_gap_max);
      end
      if (long_left > 0) begin
        long_left <= long_left - 1;
        recv_wait <= wait_now;
        result_ch.ready <= 1'b0;
      end else if (hold_requests != holds_served) begin
        holds_served <= holds_served + 1;
        long_left <= LONG_HOLD - 1;
        recv_wait <= wait_now;
        result_ch.ready <= 1'b0;
      end else if (wait_now > 0) begin
        recv_wait <= wait_now - 1;
        result_ch.ready <= 1'b0;
      end else begin
        recv_wait <= 0;
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((sample_ch.valid && sample_ch.ready) ||
                 (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_ch.valid = 1'b0;
    sample_ch.line_zero = 1'b0;
    sample_ch.line_one = 1'b0;
    result_ch.ready = 1'b0;
    mismatches = 0;
    queued_total = 0;
    hold_requests = 0;
    send_gap_max = 3;
    recv_gap_max = 3;
    spin_cw = 1'b1;
    wheel_raw = 2'b00;
    wheel_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    check_reg(REG_PPD, 32'(PPD_RESET));
    check_reg(REG_REL, 32'(REL_RESET));
    write_reg(REG_PPD, 32'd2);
    write_reg(REG_REL, 32'd20);

    // Directed: full clockwise and counter-clockwise turns, a glitch, a skip.
    push_pair(2'b00, 2);
    push_pair(2'b10, 2);
    push_pair(2'b11, 2);
    push_pair(2'b01, 2);
    push_pair(2'b00, 2);
    push_pair(2'b01, 2);
    push_pair(2'b11, 2);
    push_pair(2'b10, 2);
    push_pair(2'b00, 2);
    push_pair(2'b11, 1);
    push_pair(2'b00, 1);
    push_pair(2'b11, 2);
    push_pair(2'b00, 2);
    wheel_raw = 2'b00;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      write_reg(REG_PPD, PHASE_SPAN[ph]);
      check_reg(REG_PPD, PHASE_SPAN[ph]);
      write_reg(REG_REL, PHASE_RELEASE[ph]);
      check_reg(REG_REL, PHASE_RELEASE[ph]);
      send_gap_max = PHASE_SEND_GAP[ph];
      recv_gap_max = PHASE_RECV_GAP[ph];
      // hold off the result side while samples keep coming
      if (ph == 2)
        hold_requests++;
      queue_turns(PHASE_ITEMS);
    end
    // park the wheel long enough for the idle count to saturate
    push_pair(wheel_raw, STILL_ITEMS);
    drain_results();

    if (wheel_reports.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", wheel_reports.size()));
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
